// ===== hdl/vla_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector lane ALU package
// Opcodes, accumulator init modes and configuration register indexes.
// ----------------------------------------------------------------------------
package vla_pkg;

  localparam int unsigned DataBits = 24;
  localparam int unsigned MulBBits = 18;

  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,  OP_SUB      = 5'd1,  OP_MULL     = 5'd2,  OP_MULH     = 5'd3,
    OP_MACL     = 5'd4,  OP_MACH     = 5'd5,  OP_MACL_PRE = 5'd6,  OP_MACH_PRE = 5'd7,
    OP_XOR      = 5'd8,  OP_XNOR     = 5'd9,  OP_AND      = 5'd10, OP_NAND     = 5'd11,
    OP_OR       = 5'd12, OP_NOR      = 5'd13, OP_LSR      = 5'd14, OP_ASR      = 5'd15,
    OP_ABS      = 5'd16, OP_MIN      = 5'd17, OP_MAX      = 5'd18, OP_MINVEC   = 5'd19,
    OP_MAXVEC   = 5'd20, OP_BITREV   = 5'd21, OP_MV_ZE    = 5'd22, OP_MV_NZ    = 5'd23,
    OP_MV_MI    = 5'd24, OP_MV_PL    = 5'd25, OP_MULL_NEG = 5'd26, OP_MULH_NEG = 5'd27,
    OP_ASR_NEG  = 5'd28, OP_MULL_POS = 5'd29, OP_MULH_POS = 5'd30, OP_ASR_POS  = 5'd31
  } op_e;

  localparam logic [2:0] MAC_RST_ONCE = 3'd1;
  localparam logic [2:0] MAC_RST_Z    = 3'd2;
  localparam logic [2:0] MAC_RST_Y    = 3'd3;
  localparam logic [2:0] MAC_RST_X    = 3'd4;

  localparam logic [1:0] CFG_MUL_SHIFT = 2'd0;
  localparam logic [1:0] CFG_MAC_SHIFT = 2'd1;
  localparam logic [1:0] CFG_MAC_MODE  = 2'd2;
  localparam logic [1:0] CFG_MAC_INIT  = 2'd3;

endpackage

// ===== hdl/vector_lane_alu_with_mac.sv =====
// ----------------------------------------------------------------------------
// Vector lane ALU with multiply-accumulate
// 24-bit lane execute unit with 48-bit accumulator and vector min/max tracker.
// ----------------------------------------------------------------------------
// Pipeline: input register, then one combinational pass into the result
//   register.
// Throughput: one item per cycle unless the output stalls; the accumulator
//   and tracker update with the result, so dependent items go back to back.
// Reset: asynchronous active low; clears accumulator, tracker, configuration
//   and both valid flags.
module vector_lane_alu_with_mac #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned ACCU_BITS  = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[4:0] opa[28:5] opb[52:29] mac_init[76:53] element_index, then zero pad
  input  logic [((77 + INDEX_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // x_first[0] y_first[1] z_first[2] want_index[3] a_zero[4] a_negative[5]
  input  logic [5:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result[23:0] zero_flag[24] negative_flag[25] write_enable[26], zero pad
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import vla_pkg::*;

  localparam int unsigned DW = DataBits;

  // configuration
  logic [4:0] mul_sh_q, mac_sh_q;
  logic [2:0] mode_q;
  logic       init_op_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_sh_q <= '0; mac_sh_q <= '0; mode_q <= '0; init_op_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MUL_SHIFT: mul_sh_q  <= cfg_data_i;
        CFG_MAC_SHIFT: mac_sh_q  <= cfg_data_i;
        CFG_MAC_MODE:  mode_q    <= cfg_data_i[2:0];
        CFG_MAC_INIT:  init_op_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control: input stage and result stage
  logic in_vld_q, out_vld_q, adv;
  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;

  logic [4:0] op_q;
  logic signed [DW-1:0] a_q, b_q, init_q;
  logic [INDEX_BITS-1:0] eidx_q;
  logic [5:0] user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // capture item
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= s_axis_tdata[4:0];
      a_q    <= s_axis_tdata[28:5];
      b_q    <= s_axis_tdata[52:29];
      init_q <= s_axis_tdata[76:53];
      eidx_q <= s_axis_tdata[77 +: INDEX_BITS];
      user_q <= s_axis_tuser;
    end
  end

  logic xf, yf, zf, widx, az, an;
  assign {an, az, widx, zf, yf, xf} = user_q;

  // state
  logic [ACCU_BITS-1:0]  acc_q, acc_d;
  logic [DW-1:0]         ev_q, ev_d;
  logic [INDEX_BITS-1:0] ei_q, ei_d;
  logic [DW-1:0]         res_q, res_d;
  logic                  we_q, we_d;

  // product of A and low 18 bits of B
  logic signed [DW+MulBBits-1:0] prod;
  logic [ACCU_BITS-1:0] prod_x, acc_base, acc_init, acc_sum;
  logic [63:0] mulh_sh, mach_sh, asr_sh;
  assign prod   = a_q * $signed(b_q[MulBBits-1:0]);
  assign prod_x = ACCU_BITS'($signed(prod));

  logic due;
  always_comb begin
    due = ((mode_q == MAC_RST_ONCE) && xf && yf && zf) ||
          ((mode_q == MAC_RST_Z) && xf && yf) ||
          ((mode_q == MAC_RST_Y) && xf) || (mode_q == MAC_RST_X);
  end

  // accumulator base after optional init
  always_comb begin
    acc_init = init_op_q ? ACCU_BITS'($signed(init_q)) : '0;
    if (op_q == OP_MACH) acc_init = acc_init << mac_sh_q;
    acc_base = acc_q;
    if (due) begin
      if (op_q == OP_MACL_PRE || op_q == OP_MACH_PRE) acc_base = '0;
      else if (op_q == OP_MACL || op_q == OP_MACH) acc_base = acc_init;
    end
  end
  assign acc_sum = acc_base + prod_x;

  // shifters
  logic [4:0] sh;
  assign sh      = b_q[4:0];
  assign mulh_sh = 64'($signed(prod)) >>> mul_sh_q;
  assign mach_sh = 64'($signed(acc_sum)) >>> mac_sh_q;
  assign asr_sh  = 64'(a_q) >>> sh;

  // bit reversal of low n bits of sign-extended A
  logic [31:0] a32, brev;
  logic [5:0]  n;
  always_comb begin
    a32  = 32'(a_q);
    n    = (sh == 5'd0) ? 6'd24 : {1'b0, sh};
    brev = '0;
    for (int i = 0; i < 32; i++) begin
      if (6'(i) < n) brev[5'(n - 6'(i) - 6'd1)] = a32[i];
    end
  end

  // tracker preload and compare
  logic [DW-1:0] ev_b;
  logic [INDEX_BITS-1:0] ei_b;
  logic better;
  always_comb begin
    ev_b = ev_q;
    ei_b = ei_q;
    if ((op_q == OP_MINVEC || op_q == OP_MAXVEC) && xf && yf) begin
      ev_b = a_q;
      ei_b = eidx_q;
    end
    better = (op_q == OP_MINVEC) ? (a_q < $signed(ev_b)) : (a_q > $signed(ev_b));
  end

  // main result select
  logic cond;
  always_comb begin
    acc_d = acc_q;
    ev_d  = ev_q;
    ei_d  = ei_q;
    we_d  = 1'b1;
    cond  = 1'b1;
    res_d = '0;
    case (op_q)
      OP_ADD:  res_d = a_q + b_q;
      OP_SUB:  res_d = b_q - a_q;
      OP_MULL, OP_MULL_NEG, OP_MULL_POS: begin
        acc_d = prod_x; res_d = prod[DW-1:0];
      end
      OP_MULH, OP_MULH_NEG, OP_MULH_POS: begin
        acc_d = prod_x; res_d = mulh_sh[DW-1:0];
      end
      OP_MACL, OP_MACL_PRE: begin
        acc_d = acc_sum; res_d = acc_sum[DW-1:0];
      end
      OP_MACH, OP_MACH_PRE: begin
        acc_d = acc_sum; res_d = mach_sh[DW-1:0];
      end
      OP_XOR:  res_d = a_q ^ b_q;
      OP_XNOR: res_d = ~(a_q ^ b_q);
      OP_AND:  res_d = a_q & b_q;
      OP_NAND: res_d = ~(a_q & b_q);
      OP_OR:   res_d = a_q | b_q;
      OP_NOR:  res_d = ~(a_q | b_q);
      OP_LSR:  res_d = a_q >> sh;
      OP_ASR, OP_ASR_NEG, OP_ASR_POS: res_d = asr_sh[DW-1:0];
      OP_ABS:  res_d = a_q[DW-1] ? -a_q : a_q;
      OP_MIN:  res_d = (a_q < b_q) ? a_q : b_q;
      OP_MAX:  res_d = (a_q > b_q) ? a_q : b_q;
      OP_MINVEC, OP_MAXVEC: begin
        ev_d = better ? a_q : ev_b;
        ei_d = better ? eidx_q : ei_b;
        res_d = widx ? DW'(ei_d) : ev_d;
      end
      OP_BITREV: res_d = brev[DW-1:0];
      OP_MV_ZE: begin res_d = b_q; we_d = az;  end
      OP_MV_NZ: begin res_d = b_q; we_d = !az; end
      OP_MV_MI: begin res_d = b_q; we_d = an;  end
      OP_MV_PL: begin res_d = b_q; we_d = !an; end
      default: ;
    endcase
    if (op_q == OP_MULL_NEG || op_q == OP_MULH_NEG || op_q == OP_ASR_NEG) cond = an;
    if (op_q == OP_MULL_POS || op_q == OP_MULH_POS || op_q == OP_ASR_POS) cond = !an;
    if (!cond) res_d = a_q;
  end

  // state and result registers
  logic fire;
  assign fire = in_vld_q && adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; ev_q <= '0; ei_q <= '0; out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        acc_q <= acc_d; ev_q <= ev_d; ei_q <= ei_d;
      end
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
      we_q  <= we_d;
    end
  end

  assign m_axis_tdata = {5'd0, we_q, res_q[DW-1], (res_q == '0), res_q};

  // checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !s_axis_tready) |-> (out_vld_q && !m_axis_tready))
    else $error("input stage blocked without output stall");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(acc_q))
    else $error("accumulator moved without an item");
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_q != OP_MV_ZE && op_q != OP_MV_NZ && op_q != OP_MV_MI &&
     op_q != OP_MV_PL) |=> we_q)
    else $error("write enable dropped on unconditional op");
endmodule
